### src/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg - shared definitions of the pixel to AYCoCg converter
// Pixel format codes, configuration register indexes, field widths and the
// constants of the 16-bit channel replication.
// ----------------------------------------------------------------------------
package pac_pkg;

    // Pixel formats
    localparam logic [3:0] FMT_BGRX32 = 4'd0;
    localparam logic [3:0] FMT_BGRA32 = 4'd1;
    localparam logic [3:0] FMT_RGBX32 = 4'd2;
    localparam logic [3:0] FMT_RGBA32 = 4'd3;
    localparam logic [3:0] FMT_BGR24  = 4'd4;
    localparam logic [3:0] FMT_RGB24  = 4'd5;
    localparam logic [3:0] FMT_BGR16  = 4'd6;
    localparam logic [3:0] FMT_RGB16  = 4'd7;
    localparam logic [3:0] FMT_A4     = 4'd8;
    localparam logic [3:0] FMT_RGB8   = 4'd9;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LOSS_SHIFT = 1'd1;

    // Word fields
    localparam int unsigned FMT_W    = 4;
    localparam int unsigned LOSS_W   = 3;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned SLOT_W   = 8;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned CHAN_W   = 8;

    // Command codes
    localparam logic CMD_CONVERT   = 1'b0;
    localparam logic CMD_PAL_WRITE = 1'b1;

    // Palette
    localparam int unsigned PALETTE_ENTRIES_DEF = 256;

    // 16-bit replication masks
    localparam logic [7:0] MASK_HI5  = 8'hF8;
    localparam logic [7:0] MASK_HI3  = 8'hE0;
    localparam logic [7:0] MASK_LO5  = 8'h1F;
    localparam logic [7:0] MASK_LO3  = 8'h07;
    localparam logic [7:0] ALPHA_MAX = 8'hFF;

endpackage

### src/pac_pixel_if.sv
// ----------------------------------------------------------------------------
// pac_pixel_if - source pixel channel
// Valid/ready channel carrying one convert or palette write word.
// ----------------------------------------------------------------------------
interface pac_pixel_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] pixel_bits;
    logic [2:0]  plane_position;
    logic [7:0]  palette_slot;
    logic [23:0] palette_color;

    modport source (
        output valid, cmd, pixel_bits, plane_position, palette_slot, palette_color,
        input  ready
    );

    modport sink (
        input  valid, cmd, pixel_bits, plane_position, palette_slot, palette_color,
        output ready
    );
endinterface

### src/pac_result_if.sv
// ----------------------------------------------------------------------------
// pac_result_if - AYCoCg result channel
// Valid/ready channel carrying luma, both chroma bytes and alpha.
// ----------------------------------------------------------------------------
interface pac_result_if;
    logic              valid;
    logic              ready;
    logic [7:0]        luma;
    logic signed [7:0] chroma_orange;
    logic signed [7:0] chroma_green;
    logic [7:0]        alpha;

    modport source (
        output valid, luma, chroma_orange, chroma_green, alpha,
        input  ready
    );

    modport sink (
        input  valid, luma, chroma_orange, chroma_green, alpha,
        output ready
    );
endinterface

### src/pac_ram.sv
// ----------------------------------------------------------------------------
// pac_ram - generic simple dual port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module pac_ram #(
    parameter int unsigned WIDTH  = pac_pkg::COLOR_W,
    parameter int unsigned DEPTH  = pac_pkg::PALETTE_ENTRIES_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### src/pixel_to_aycocg_converter_unit.sv
// ----------------------------------------------------------------------------
// pixel_to_aycocg_converter_unit - pixel to AYCoCg color converter
// Unpacks one source pixel per word and emits luma, Co, Cg and alpha.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output is not stalled; a full,
// blocked stage 1 holds the input off. A convert word yields one result: on
// acceptance it issues the palette RAM read (its read data is registered),
// then stage 1 unpacks the channels and computes luma and chroma into the
// output register. A palette write word yields no result; an entry written
// is visible to a convert word accepted in the next cycle. The palette is not
// cleared after reset, so entries must be loaded before an A4 or RGB8 pixel
// reads them. The user must write pixel_format and color_loss_shift through
// the configuration port only while the block is idle; the block does not enforce it.
module pixel_to_aycocg_converter_unit #(
    parameter int unsigned PALETTE_ENTRIES = pac_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pac_pixel_if.sink                      i_pix,
    pac_result_if.source                   o_res
);
    import pac_pkg::*;

    localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);

    // Configuration registers
    logic [FMT_W-1:0]  r_format;
    logic [LOSS_W-1:0] r_loss;

    // Handshake
    logic pix_acc;
    logic s1_adv;

    // Stage 0: palette index
    logic [SLOT_W-1:0] pal_idx;
    logic [2:0]        plane_bit;
    logic              rd_oob;
    logic              wr_ok;
    logic              wr_en;
    logic              rd_en;
    logic [COLOR_W-1:0] ram_rd_data;

    // Stage 1 registers
    logic               r_s1_valid;
    logic [FMT_W-1:0]   r_s1_format;
    logic [PIXEL_W-1:0] r_s1_pixel;
    logic               r_s1_oob;

    // Stage 1 datapath
    logic [7:0]         b0, b1, b2, b3;
    logic [7:0]         hi, mid, lo;
    logic [COLOR_W-1:0] pal_color;
    logic [7:0]         ch_r, ch_g, ch_b, ch_a;
    logic [7:0]         n_luma;
    logic signed [8:0]  co_raw, co_sh;
    logic signed [9:0]  cg_raw, cg_sh;
    logic [7:0]         n_co, n_cg;

    // Output register
    logic               r_out_valid;
    logic [7:0]         r_luma;
    logic [7:0]         r_co;
    logic [7:0]         r_cg;
    logic [7:0]         r_alpha;

    // Advance stage 1 whenever the output register is free or drains
    assign s1_adv      = !r_out_valid || o_res.ready;
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_BGRX32;
            r_loss   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIXEL_FORMAT:     r_format <= i_cfg_data;
                CFG_COLOR_LOSS_SHIFT: r_loss   <= i_cfg_data[LOSS_W-1:0];
                default:              r_format <= r_format;
            endcase
        end
    end

    // Pick the palette index: A4 gathers one bit of each byte, RGB8 uses byte 0
    assign plane_bit = 3'd7 - i_pix.plane_position;
    always_comb begin
        priority if (r_format == FMT_A4) begin
            pal_idx = {4'd0,
                       i_pix.pixel_bits[24 + plane_bit],
                       i_pix.pixel_bits[16 + plane_bit],
                       i_pix.pixel_bits[8 + plane_bit],
                       i_pix.pixel_bits[plane_bit]};
        end else begin
            pal_idx = i_pix.pixel_bits[7:0];
        end
    end

    assign rd_oob = {1'b0, pal_idx} >= (SLOT_W + 1)'(PALETTE_ENTRIES);
    assign wr_ok  = {1'b0, i_pix.palette_slot} < (SLOT_W + 1)'(PALETTE_ENTRIES);
    assign wr_en  = pix_acc && (i_pix.cmd == CMD_PAL_WRITE) && wr_ok;
    assign rd_en  = pix_acc && (i_pix.cmd == CMD_CONVERT);

    pac_ram #(
        .WIDTH  (COLOR_W),
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_pix.palette_slot[ADDR_W-1:0]),
        .i_wr_data (i_pix.palette_color),
        .i_rd_en   (rd_en),
        .i_rd_addr (pal_idx[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // Load stage 1 with convert words only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_format <= r_format;
            r_s1_pixel  <= i_pix.pixel_bits;
            r_s1_oob    <= rd_oob;
        end
    end

    // Expand 5-6-5 channels to bytes
    assign b0  = r_s1_pixel[7:0];
    assign b1  = r_s1_pixel[15:8];
    assign b2  = r_s1_pixel[23:16];
    assign b3  = r_s1_pixel[31:24];
    assign hi  = (b1 & MASK_HI5) | (b1 >> 5);
    assign mid = ((b1 & MASK_LO3) << 5) | ((b0 & MASK_HI3) >> 3);
    assign lo  = ((b0 & MASK_LO5) << 3) | ((b0 >> 2) & MASK_LO3);

    // Drop palette data for indexes past the end
    assign pal_color = r_s1_oob ? '0 : ram_rd_data;

    // Unpack R, G, B and A
    always_comb begin
        ch_r = '0;
        ch_g = '0;
        ch_b = '0;
        ch_a = ALPHA_MAX;
        unique case (r_s1_format)
            FMT_BGRX32, FMT_BGR24: begin
                ch_b = b0; ch_g = b1; ch_r = b2;
            end
            FMT_BGRA32: begin
                ch_b = b0; ch_g = b1; ch_r = b2; ch_a = b3;
            end
            FMT_RGBX32, FMT_RGB24: begin
                ch_r = b0; ch_g = b1; ch_b = b2;
            end
            FMT_RGBA32: begin
                ch_r = b0; ch_g = b1; ch_b = b2; ch_a = b3;
            end
            FMT_BGR16: begin
                ch_b = hi; ch_g = mid; ch_r = lo;
            end
            FMT_RGB16: begin
                ch_r = hi; ch_g = mid; ch_b = lo;
            end
            FMT_A4, FMT_RGB8: begin
                ch_r = pal_color[7:0];
                ch_g = pal_color[15:8];
                ch_b = pal_color[23:16];
            end
            default: begin
                ch_a = '0;
            end
        endcase
    end

    // Luma peaks at 253, so eight bits never overflow
    assign n_luma = {2'b00, ch_r[7:2]} + {1'b0, ch_g[7:1]} + {2'b00, ch_b[7:2]};

    // Chroma with loss shift and signed byte saturation
    assign co_raw = $signed({1'b0, ch_r}) - $signed({1'b0, ch_b});
    assign cg_raw = $signed({2'b00, ch_g}) - $signed({3'b000, ch_r[7:1]})
                  - $signed({3'b000, ch_b[7:1]});
    assign co_sh  = co_raw >>> r_loss;
    assign cg_sh  = cg_raw >>> r_loss;

    always_comb begin
        priority if (co_sh > 9'sd127) begin
            n_co = 8'h7F;
        end else if (co_sh < -9'sd128) begin
            n_co = 8'h80;
        end else begin
            n_co = co_sh[7:0];
        end
        priority if (cg_sh > 10'sd127) begin
            n_cg = 8'h7F;
        end else if (cg_sh < -10'sd128) begin
            n_cg = 8'h80;
        end else begin
            n_cg = cg_sh[7:0];
        end
    end

    // Advance the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_luma  <= n_luma;
            r_co    <= n_co;
            r_cg    <= n_cg;
            r_alpha <= ch_a;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.luma          = r_luma;
    assign o_res.chroma_orange = r_co;
    assign o_res.chroma_green  = r_cg;
    assign o_res.alpha         = r_alpha;

    // A palette write leaves no word in stage 1
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && i_pix.cmd == CMD_PAL_WRITE) |=> !r_s1_valid)
        else $error("palette write entered the result pipeline");

    // A blocked stage 1 keeps its word and its palette data
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(ram_rd_data)))
        else $error("stage 1 word or palette data lost while stalled");

    // A convert word advancing out of stage 1 lands in the output register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> r_out_valid)
        else $error("stage 1 word dropped on advance");

    // No word is taken while stage 1 is full and blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !pix_acc)
        else $error("word accepted over a blocked stage 1");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking regression of the pixel to AYCoCg converter
// Loads the palette, runs a short directed set for several pixel formats, then random
// words across format and color loss settings. A predictor with
// its own palette copy queues the expected AYCoCg words. The monitor compares
// every result word against the oldest queued word, field by field.
// ----------------------------------------------------------------------------
module testbench;
    import pac_pkg::*;

    localparam int          PAL_ENTRIES     = PALETTE_ENTRIES_DEF;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          MAX_REPORTS     = 10;
    localparam int          RANDOM_PER_MODE = 75;
    localparam int          MODE_COUNT      = 12;
    localparam logic [3:0]  FMT_UNKNOWN     = 4'd10;
    localparam logic [3:0]  FMT_UNKNOWN_TOP = 4'd15;

    typedef struct packed {
        logic               cmd;
        logic [PIXEL_W-1:0] pixel_bits;
        logic [POS_W-1:0]   plane_position;
        logic [SLOT_W-1:0]  palette_slot;
        logic [COLOR_W-1:0] palette_color;
    } pixel_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] luma;
        logic [CHAN_W-1:0] chroma_orange;
        logic [CHAN_W-1:0] chroma_green;
        logic [CHAN_W-1:0] alpha;
    } aycocg_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pac_pixel_if  pix_bus ();
    pac_result_if res_bus ();

    pixel_to_aycocg_converter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_bus),
        .o_res       (res_bus)
    );

    // Predictor state: configuration and palette as the block holds them
    logic [FMT_W-1:0]   cur_format;
    logic [LOSS_W-1:0]  cur_loss;
    logic [COLOR_W-1:0] palette_copy [PAL_ENTRIES];

    pixel_word_t pixel_words_pending [$];
    aycocg_t     expected_aycocg [$];

    int          words_queued;
    int          words_sent;
    int          mismatch_count;
    int          idle_cycles;
    bit          hold_off;
    logic        word_taken;
    int          burst_left;
    int          gap_left;
    pixel_word_t next_word;
    logic [15:0] stall_pattern;
    logic [5:0]  stall_step;
    aycocg_t     got_word;
    aycocg_t     exp_word;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Clamp to a signed byte
    function automatic logic [CHAN_W-1:0] sat_byte(input int v);
        if (v > 127) begin
            return 8'h7F;
        end
        if (v < -128) begin
            return 8'h80;
        end
        return v[7:0];
    endfunction

    // Unpack one pixel under the current format and compute AYCoCg
    function automatic aycocg_t convert_pixel(input logic [PIXEL_W-1:0] px,
                                              input logic [POS_W-1:0] pos);
        logic [7:0]         b0, b1, b2, b3, hi, mid, lo;
        logic [COLOR_W-1:0] col;
        int                 r, g, b, a, bitpos, idx;
        aycocg_t            res;
        b0 = px[7:0];
        b1 = px[15:8];
        b2 = px[23:16];
        b3 = px[31:24];
        r = 0;
        g = 0;
        b = 0;
        a = 255;
        hi  = (b1 & MASK_HI5) | (b1 >> 5);
        mid = ((b1 & MASK_LO3) << 5) | ((b0 & MASK_HI3) >> 3);
        lo  = ((b0 & MASK_LO5) << 3) | ((b0 >> 2) & MASK_LO3);
        case (cur_format)
            FMT_BGRX32, FMT_BGR24: begin
                b = b0; g = b1; r = b2;
            end
            FMT_BGRA32: begin
                b = b0; g = b1; r = b2; a = b3;
            end
            FMT_RGBX32, FMT_RGB24: begin
                r = b0; g = b1; b = b2;
            end
            FMT_RGBA32: begin
                r = b0; g = b1; b = b2; a = b3;
            end
            FMT_BGR16: begin
                b = hi; g = mid; r = lo;
            end
            FMT_RGB16: begin
                r = hi; g = mid; b = lo;
            end
            FMT_A4, FMT_RGB8: begin
                if (cur_format == FMT_A4) begin
                    bitpos = 7 - pos;
                    idx = {b3[bitpos], b2[bitpos], b1[bitpos], b0[bitpos]};
                end else begin
                    idx = b0;
                end
                col = (idx < PAL_ENTRIES) ? palette_copy[idx] : '0;
                r = col[7:0];
                g = col[15:8];
                b = col[23:16];
            end
            default: begin
                a = 0;
            end
        endcase
        res.luma = ((r >> 2) + (g >> 1) + (b >> 2) > 255) ? 8'hFF :
                   8'((r >> 2) + (g >> 1) + (b >> 2));
        res.chroma_orange = sat_byte((r - b) >>> cur_loss);
        res.chroma_green  = sat_byte((g - (r >> 1) - (b >> 1)) >>> cur_loss);
        res.alpha = a[7:0];
        return res;
    endfunction

    // Sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else if (!pix_bus.valid || word_taken) begin
            if (hold_off || gap_left != 0 || pixel_words_pending.size() == 0) begin
                pix_bus.valid <= 1'b0;
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end
            end else begin
                next_word = pixel_words_pending.pop_front();
                pix_bus.valid          <= 1'b1;
                pix_bus.cmd            <= next_word.cmd;
                pix_bus.pixel_bits     <= next_word.pixel_bits;
                pix_bus.plane_position <= next_word.plane_position;
                pix_bus.palette_slot   <= next_word.palette_slot;
                pix_bus.palette_color  <= next_word.palette_color;
                if (burst_left <= 1) begin
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left <= 64;
                        gap_left   <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= $urandom_range(1, 6);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: stall on a rotating pattern, refreshed each time the step counter wraps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (stall_step == 0) begin
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                                16'($urandom | 1);
            end
            res_bus.ready <= stall_pattern[stall_step[3:0]];
            stall_step    <= stall_step + 6'd1;
        end
    end

    // Monitor: check result words, then predict from accepted pixel words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken  <= 1'b0;
            idle_cycles <= 0;
        end else begin
            word_taken <= pix_bus.valid && pix_bus.ready;
            if (res_bus.valid && res_bus.ready) begin
                got_word = {res_bus.luma, res_bus.chroma_orange,
                            res_bus.chroma_green, res_bus.alpha};
                if (expected_aycocg.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected result word: Y %0d Co %0d Cg %0d A %0d",
                                 got_word.luma, $signed(got_word.chroma_orange),
                                 $signed(got_word.chroma_green), got_word.alpha);
                    end
                end else begin
                    exp_word = expected_aycocg.pop_front();
                    if (got_word !== exp_word) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("result mismatch: exp Y %0d Co %0d Cg %0d A %0d, %s",
                                     exp_word.luma, $signed(exp_word.chroma_orange),
                                     $signed(exp_word.chroma_green), exp_word.alpha,
                                     "see next line");
                            $display("                 got Y %0d Co %0d Cg %0d A %0d",
                                     got_word.luma, $signed(got_word.chroma_orange),
                                     $signed(got_word.chroma_green), got_word.alpha);
                        end
                    end
                end
            end
            if (pix_bus.valid && pix_bus.ready) begin
                words_sent++;
                if (pix_bus.cmd == CMD_PAL_WRITE) begin
                    if (pix_bus.palette_slot < PAL_ENTRIES) begin
                        palette_copy[pix_bus.palette_slot] = pix_bus.palette_color;
                    end
                end else begin
                    expected_aycocg.push_back(convert_pixel(pix_bus.pixel_bits,
                                                            pix_bus.plane_position));
                end
            end
            // Watchdog on cycles without any handshake
            if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Queue one word for the sender
    task automatic send_word(input logic cmd, input logic [PIXEL_W-1:0] px,
                             input logic [POS_W-1:0] pos, input logic [SLOT_W-1:0] slot,
                             input logic [COLOR_W-1:0] color);
        pixel_word_t w;
        w.cmd            = cmd;
        w.pixel_bits     = px;
        w.plane_position = pos;
        w.palette_slot   = slot;
        w.palette_color  = color;
        pixel_words_pending.push_back(w);
        words_queued++;
    endtask

    // Wait until every word is taken and every result is back, then settle
    task automatic drain();
        while (words_sent != words_queued || expected_aycocg.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Idle the block, write both registers, then resume on a rising edge
    task automatic set_mode(input logic [FMT_W-1:0] fmt, input logic [LOSS_W-1:0] loss);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PIXEL_FORMAT;
        i_cfg_data  <= CFG_DATA_W'(fmt);
        @(negedge i_clk);
        i_cfg_index <= CFG_COLOR_LOSS_SHIFT;
        i_cfg_data  <= CFG_DATA_W'(loss);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_format  = fmt;
        cur_loss    = loss;
        @(posedge i_clk);
    endtask

    // Random words: mostly converts, some palette writes read back at once
    task automatic queue_random(input int count);
        logic [PIXEL_W-1:0] px;
        logic [POS_W-1:0]   pos;
        logic [SLOT_W-1:0]  slot;
        for (int n = 0; n < count; n++) begin
            pos = POS_W'($urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0) begin
                slot = (cur_format == FMT_A4) ? SLOT_W'($urandom_range(0, 15)) :
                                                SLOT_W'($urandom_range(0, 255));
                send_word(CMD_PAL_WRITE, $urandom, pos, slot, COLOR_W'($urandom));
                if ((cur_format == FMT_A4 || cur_format == FMT_RGB8) && $urandom_range(0, 1)) begin
                    px = $urandom;
                    if (cur_format == FMT_RGB8) begin
                        px[7:0] = slot;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            px[8 * k + 7 - pos] = slot[k];
                        end
                    end
                    send_word(CMD_CONVERT, px, pos, SLOT_W'($urandom), COLOR_W'($urandom));
                end
            end else begin
                px = $urandom;
                if ($urandom_range(0, 7) == 0) begin
                    // Extreme byte values
                    for (int k = 0; k < 4; k++) begin
                        case ($urandom_range(0, 3))
                            0: px[8 * k +: 8] = 8'h00;
                            1: px[8 * k +: 8] = 8'hFF;
                            2: px[8 * k +: 8] = 8'h80;
                            default: px[8 * k +: 8] = 8'h7F;
                        endcase
                    end
                end
                send_word(CMD_CONVERT, px, pos, SLOT_W'($urandom), COLOR_W'($urandom));
            end
        end
    endtask

    // Stimulus
    initial begin
        logic [FMT_W-1:0] fmt;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = '0;
        i_cfg_data             = '0;
        pix_bus.valid          = 1'b0;
        pix_bus.cmd            = CMD_CONVERT;
        pix_bus.pixel_bits     = '0;
        pix_bus.plane_position = '0;
        pix_bus.palette_slot   = '0;
        pix_bus.palette_color  = '0;
        res_bus.ready          = 1'b0;
        cur_format             = FMT_BGRX32;
        cur_loss               = '0;
        words_queued           = 0;
        words_sent             = 0;
        mismatch_count         = 0;
        hold_off               = 1'b0;
        burst_left             = 1;
        gap_left               = 0;
        stall_pattern          = 16'hFFFF;
        stall_step             = '0;
        for (int i = 0; i < PAL_ENTRIES; i++) begin
            palette_copy[i] = '0;
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every palette entry so no lookup hits an unwritten one
        for (int i = 0; i < PAL_ENTRIES; i++) begin
            send_word(CMD_PAL_WRITE, $urandom, POS_W'($urandom), i[SLOT_W-1:0],
                      COLOR_W'($urandom));
        end

        // Directed: channel extremes and chroma saturation both ways
        set_mode(FMT_RGBA32, 3'd0);
        send_word(CMD_CONVERT, 32'h0000_0000, 3'd0, 8'h00, 24'h0);
        send_word(CMD_CONVERT, 32'hFFFF_FFFF, 3'd7, 8'hFF, 24'hFFFFFF);
        send_word(CMD_CONVERT, 32'h0000_00FF, 3'd0, 8'h00, 24'h0);
        send_word(CMD_CONVERT, 32'h00FF_0000, 3'd0, 8'h00, 24'h0);
        send_word(CMD_CONVERT, 32'h0000_FF00, 3'd0, 8'h00, 24'h0);
        set_mode(FMT_RGBA32, 3'd7);
        send_word(CMD_CONVERT, 32'h0000_00FF, 3'd0, 8'h00, 24'h0);
        send_word(CMD_CONVERT, 32'h00FF_0000, 3'd0, 8'h00, 24'h0);

        // Directed: 16-bit replication, upper bytes ignored
        set_mode(FMT_BGR16, 3'd0);
        send_word(CMD_CONVERT, 32'hFFFF_FFFF, 3'd0, 8'h00, 24'h0);
        send_word(CMD_CONVERT, 32'hA5A5_0000, 3'd0, 8'h00, 24'h0);
        set_mode(FMT_RGB16, 3'd0);
        send_word(CMD_CONVERT, 32'h0000_F81F, 3'd0, 8'h00, 24'h0);
        send_word(CMD_CONVERT, 32'h0000_07E0, 3'd0, 8'h00, 24'h0);

        // Directed: palette written and read back by the following word
        set_mode(FMT_RGB8, 3'd0);
        send_word(CMD_PAL_WRITE, 32'h0, 3'd0, 8'h00, 24'h0000FF);
        send_word(CMD_CONVERT, 32'hFFFF_FF00, 3'd5, 8'h00, 24'h0);
        send_word(CMD_PAL_WRITE, 32'h0, 3'd0, 8'hFF, 24'hFF0000);
        send_word(CMD_CONVERT, 32'h0000_00FF, 3'd2, 8'h00, 24'h0);

        // Directed: bit-plane index at both ends of the group
        set_mode(FMT_A4, 3'd0);
        send_word(CMD_PAL_WRITE, 32'h0, 3'd0, 8'h0F, 24'hFFFFFF);
        send_word(CMD_CONVERT, 32'h8080_8080, 3'd0, 8'h00, 24'h0);
        send_word(CMD_CONVERT, 32'h0101_0101, 3'd7, 8'h00, 24'h0);
        send_word(CMD_CONVERT, 32'hFEFE_FEFE, 3'd7, 8'h00, 24'h0);

        // Directed: unknown format gives all zeros
        set_mode(FMT_UNKNOWN, 3'd0);
        send_word(CMD_CONVERT, 32'hFFFF_FFFF, 3'd0, 8'h00, 24'h0);

        // Random words over every format and every loss shift
        for (int m = 0; m < MODE_COUNT; m++) begin
            case (m)
                0:  fmt = FMT_BGRX32;
                1:  fmt = FMT_BGRA32;
                2:  fmt = FMT_RGBX32;
                3:  fmt = FMT_RGBA32;
                4:  fmt = FMT_BGR24;
                5:  fmt = FMT_RGB24;
                6:  fmt = FMT_BGR16;
                7:  fmt = FMT_RGB16;
                8:  fmt = FMT_A4;
                9:  fmt = FMT_RGB8;
                10: fmt = FMT_UNKNOWN;
                default: fmt = FMT_UNKNOWN_TOP;
            endcase
            set_mode(fmt, LOSS_W'((m * 3) % 8));
            queue_random(RANDOM_PER_MODE);
            if (m == 5) begin
                // Pause the sender mid-phase until all results are back
                while (words_sent < words_queued - 40) begin
                    @(negedge i_clk);
                end
                @(posedge i_clk);
                hold_off = 1'b1;
                while (expected_aycocg.size() != 0) begin
                    @(negedge i_clk);
                end
                @(posedge i_clk);
                hold_off = 1'b0;
            end
        end

        drain();
        if (mismatch_count == 0 && expected_aycocg.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
